// File: rtl/subtractive_lagged_fibonacci_rng_top_assert.svh
// assertion helpers used by the rng top
`ifndef SUBTRACTIVE_LAGGED_FIBONACCI_RNG_TOP_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_FIBONACCI_RNG_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLFR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SLFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/slfr_pkg.sv
`timescale 1ns / 1ps

package slfr_pkg;

	// table geometry and lags
	localparam int TABLE_LEN = 55;
	localparam int SHORT_LAG = 24;
	localparam int LONG_LAG  = 31;
	localparam int FILL_STEP = 21;
	localparam int FILL_MOD  = 54;
	localparam int IDX_W     = 6;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [1:0]       op_t;

	// operation codes
	localparam op_t OP_WARM = 2'd0;
	localparam op_t OP_INT  = 2'd1;
	localparam op_t OP_REAL = 2'd2;

	// table port control from the sequencer
	typedef struct packed {
		logic we;
		logic clr;
		idx_t waddr;
		idx_t raddr0;
		idx_t raddr1;
	} tbl_ctrl_t;

	// scaler request
	typedef struct packed {
		logic start;
		logic is_real;
	} scl_req_t;

endpackage

// File: rtl/subtractive_lagged_fibonacci_rng_top.sv
`timescale 1ns / 1ps

// channel    direction  handshake          payload
// s_*        in         s_tvalid/s_tready  tuser: op; tdata: low, high
// m_*        out        m_tvalid/m_tready  tdata: fraction, value
// cfg_*      in         cfg_we             cfg_wdata: seed
//
// a draw runs through accept, table read, latch, three scaler stages, output load
// a draw whose read index wraps first refreshes the table on the shared subtractor
// warm-up runs through accept, clear, a fill of 54 writes, three refreshes, output load
// an empty integer range or the unused op goes from accept straight to output load
// after reset the table reads as zero through per-entry valid bits, no clearing pass
// s_tready is high only while idle; a word waiting on m_* holds up only the output load of the next one

module subtractive_lagged_fibonacci_rng_top import slfr_pkg::*; #(
	parameter int FRAC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // low [31:0], high [63:32]
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // fraction [31:0], value [63:32]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	`include "subtractive_lagged_fibonacci_rng_top_assert.svh"

	localparam int SH_UP = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
	localparam int SH_DN = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
	localparam logic [63:0] START_FULL = HALF / 64'd500000000
		+ (((HALF % 64'd500000000) >= 64'd250000000) ? 64'd1 : 64'd0);
	localparam logic [FRAC_BITS-1:0] START = START_FULL[FRAC_BITS-1:0];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_FILL,
		ST_REF,
		ST_DRD,
		ST_DLAT,
		ST_SCL,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [31:0]          seed_q;
	op_t                  op_q;
	logic signed [31:0]   low_q;
	logic signed [31:0]   high_q;
	idx_t                 read_index_q;
	idx_t                 pos_q;
	idx_t                 fill_cnt_q;
	logic [FRAC_BITS-1:0] prev_q;
	logic [FRAC_BITS-1:0] nxt_q;
	idx_t                 ref_k_q;
	logic [1:0]           ref_cnt_q;
	logic                 warm_q;
	idx_t                 wk_s1;
	logic                 wv_s1;
	logic [31:0]          frac_q;
	logic signed [31:0]   value_q;
	logic                 m_tvalid_q;
	logic [63:0]          m_tdata_q;

	tbl_ctrl_t            tbl_ctrl;
	logic [FRAC_BITS-1:0] tbl_wdata;
	logic [FRAC_BITS-1:0] tbl_rdata0;
	logic [FRAC_BITS-1:0] tbl_rdata1;
	logic [FRAC_BITS-1:0] seed_w;
	logic [31:0]          frac_w;
	logic [FRAC_BITS-1:0] sub_a_w;
	logic [FRAC_BITS-1:0] sub_b_w;
	logic [FRAC_BITS-1:0] sub_w;
	idx_t                 idx_cl_w;
	idx_t                 idx_inc_w;
	logic                 draw_wrap_w;
	idx_t                 ref_part_w;
	logic [IDX_W:0]       pos_sum_w;
	idx_t                 pos_next_w;
	logic signed [31:0]   in_low_w;
	logic signed [31:0]   in_high_w;
	logic                 draw_acc_w;
	scl_req_t             scl_req;
	logic                 scl_done;
	logic signed [31:0]   scl_value;

	assign in_low_w  = s_tdata[31:0];
	assign in_high_w = s_tdata[63:32];

	// accepted word that makes a draw
	assign draw_acc_w = s_tvalid && s_tready
		&& (s_tuser == OP_REAL || (s_tuser == OP_INT && in_low_w < in_high_w));

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'h8000_0000;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// conversion between q0.32 and the table fraction width
	if (FRAC_BITS >= 32) begin : g_wide
		assign seed_w = FRAC_BITS'(seed_q) << SH_UP;
		assign frac_w = 32'(tbl_rdata0 >> SH_UP);
	end else begin : g_narrow
		assign seed_w = FRAC_BITS'(seed_q >> SH_DN);
		assign frac_w = 32'(tbl_rdata0) << SH_DN;
	end

	// shared modular subtractor: fill recurrence or table refresh
	assign sub_a_w = (state_q == ST_FILL) ? prev_q : tbl_rdata0;
	assign sub_b_w = (state_q == ST_FILL) ? nxt_q  : tbl_rdata1;
	assign sub_w   = sub_a_w - sub_b_w;

	// next read index
	assign idx_cl_w    = (read_index_q > idx_t'(TABLE_LEN - 1)) ? idx_t'(TABLE_LEN - 1)
		: read_index_q;
	assign idx_inc_w   = idx_cl_w + idx_t'(1);
	assign draw_wrap_w = (idx_inc_w == idx_t'(TABLE_LEN));

	// refresh partner entry
	assign ref_part_w = (ref_k_q < idx_t'(SHORT_LAG)) ? ref_k_q + idx_t'(LONG_LAG)
		: ref_k_q - idx_t'(SHORT_LAG);

	// fill position steps by 21 modulo 54
	assign pos_sum_w  = {1'b0, pos_q} + (IDX_W + 1)'(FILL_STEP);
	assign pos_next_w = (pos_sum_w >= (IDX_W + 1)'(FILL_MOD))
		? idx_t'(pos_sum_w - (IDX_W + 1)'(FILL_MOD)) : idx_t'(pos_sum_w);

	// table port control
	always_comb begin
		tbl_ctrl.we     = 1'b0;
		tbl_ctrl.clr    = 1'b0;
		tbl_ctrl.waddr  = wk_s1;
		tbl_ctrl.raddr0 = ref_k_q;
		tbl_ctrl.raddr1 = ref_part_w;
		tbl_wdata       = sub_w;
		case (state_q)
			ST_CLR: begin
				tbl_ctrl.clr   = 1'b1;
				tbl_ctrl.we    = 1'b1;
				tbl_ctrl.waddr = idx_t'(TABLE_LEN - 1);
				tbl_wdata      = seed_w;
			end
			ST_FILL: begin
				tbl_ctrl.we    = 1'b1;
				tbl_ctrl.waddr = pos_q;
				tbl_wdata      = nxt_q;
			end
			ST_REF: begin
				tbl_ctrl.we = wv_s1;
			end
			ST_DRD: begin
				tbl_ctrl.raddr0 = read_index_q;
			end
			default: begin
			end
		endcase
	end

	assign scl_req.start   = (state_q == ST_DLAT);
	assign scl_req.is_real = (op_q == OP_REAL);

	slfr_table #(
		.FRAC_BITS(FRAC_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tbl_ctrl),
		.wdata  (tbl_wdata),
		.rdata0 (tbl_rdata0),
		.rdata1 (tbl_rdata1)
	);

	slfr_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (scl_req),
		.fraction_in (frac_w),
		.low         (low_q),
		.high        (high_q),
		.done        (scl_done),
		.value       (scl_value)
	);

	// sequencer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_WARM;
			low_q        <= '0;
			high_q       <= '0;
			read_index_q <= '0;
			pos_q        <= '0;
			fill_cnt_q   <= '0;
			prev_q       <= '0;
			nxt_q        <= '0;
			ref_k_q      <= '0;
			ref_cnt_q    <= '0;
			warm_q       <= 1'b0;
			wk_s1        <= '0;
			wv_s1        <= 1'b0;
			frac_q       <= '0;
			value_q      <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			wk_s1 <= ref_k_q;
			wv_s1 <= (state_q == ST_REF) && (ref_k_q != idx_t'(TABLE_LEN));
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						low_q   <= in_low_w;
						high_q  <= in_high_w;
						frac_q  <= '0;
						value_q <= '0;
						if (s_tuser == OP_WARM) begin
							state_q <= ST_CLR;
						end else if ((s_tuser == OP_INT && in_low_w < in_high_w)
							|| s_tuser == OP_REAL) begin
							read_index_q <= draw_wrap_w ? idx_t'(1) : idx_inc_w;
							warm_q       <= 1'b0;
							ref_k_q      <= '0;
							state_q      <= draw_wrap_w ? ST_REF : ST_DRD;
						end else begin
							// empty integer range answers low, unused op answers zero
							if (s_tuser == OP_INT) begin
								value_q <= in_low_w;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLR: begin
					prev_q     <= seed_w;
					nxt_q      <= START;
					pos_q      <= idx_t'(FILL_STEP);
					fill_cnt_q <= idx_t'(1);
					state_q    <= ST_FILL;
				end
				ST_FILL: begin
					nxt_q      <= sub_w;
					prev_q     <= nxt_q;
					pos_q      <= pos_next_w;
					fill_cnt_q <= fill_cnt_q + idx_t'(1);
					if (fill_cnt_q == idx_t'(FILL_MOD)) begin
						ref_k_q   <= '0;
						ref_cnt_q <= '0;
						warm_q    <= 1'b1;
						state_q   <= ST_REF;
					end
				end
				ST_REF: begin
					if (ref_k_q != idx_t'(TABLE_LEN)) begin
						ref_k_q <= ref_k_q + idx_t'(1);
					end else if (warm_q && ref_cnt_q != 2'd2) begin
						ref_cnt_q <= ref_cnt_q + 2'd1;
						ref_k_q   <= '0;
					end else if (warm_q) begin
						read_index_q <= '0;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					state_q <= ST_DLAT;
				end
				ST_DLAT: begin
					frac_q  <= frac_w;
					state_q <= ST_SCL;
				end
				ST_SCL: begin
					if (scl_done) begin
						value_q <= scl_value;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {value_q, frac_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SLFR_ASSERT_IMPL(a_idx_range, 1'b1, read_index_q <= idx_t'(TABLE_LEN - 1), "index past table")
	`SLFR_ASSERT_IMPL(a_fill_pos, state_q == ST_FILL, pos_q < idx_t'(FILL_MOD), "bad fill position")
	`SLFR_ASSERT_NEXT(a_draw_moves, draw_acc_w, read_index_q != $past(read_index_q), "index stuck")
	`SLFR_ASSERT_IMPL(a_scale_done, scl_done, state_q == ST_SCL, "scaler done outside wait state")
	`SLFR_ASSERT_IMPL(a_idle_no_write, state_q == ST_IDLE, !tbl_ctrl.we, "table write while idle")

endmodule

// File: rtl/slfr_table.sv
`timescale 1ns / 1ps

module slfr_table import slfr_pkg::*; #(
	parameter int FRAC_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_ctrl_t            ctrl,
	input  logic [FRAC_BITS-1:0] wdata,
	output logic [FRAC_BITS-1:0] rdata0,
	output logic [FRAC_BITS-1:0] rdata1
);

	logic [FRAC_BITS-1:0] mem [TABLE_LEN];
	logic [TABLE_LEN-1:0] valid_q;
	logic [FRAC_BITS-1:0] rd0_q;
	logic [FRAC_BITS-1:0] rd1_q;
	logic                 rv0_q;
	logic                 rv1_q;

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= wdata;
		end
		rd0_q <= mem[ctrl.raddr0];
		rd1_q <= mem[ctrl.raddr1];
	end

	// per-entry valid bits, an entry not written since reset or the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv0_q   <= 1'b0;
			rv1_q   <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				valid_q <= ctrl.we ? (TABLE_LEN'(1) << ctrl.waddr) : '0;
			end else if (ctrl.we) begin
				valid_q[ctrl.waddr] <= 1'b1;
			end
			rv0_q <= valid_q[ctrl.raddr0];
			rv1_q <= valid_q[ctrl.raddr1];
		end
	end

	assign rdata0 = rv0_q ? rd0_q : '0;
	assign rdata1 = rv1_q ? rd1_q : '0;

endmodule

// File: rtl/slfr_scale.sv
`timescale 1ns / 1ps

module slfr_scale import slfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  scl_req_t           req,
	input  logic [31:0]        fraction_in,
	input  logic signed [31:0] low,
	input  logic signed [31:0] high,
	output logic               done,
	output logic signed [31:0] value
);

	logic signed [32:0] diff_w;
	logic [32:0]        span_w;
	logic [32:0]        mag_w;

	logic               v_s1;
	logic               real_s1;
	logic               neg_s1;
	logic [31:0]        f_s1;
	logic [32:0]        opnd_s1;
	logic signed [31:0] lo_s1;
	logic signed [31:0] hi_s1;

	logic               v_s2;
	logic               real_s2;
	logic               neg_s2;
	logic [64:0]        prod_s2;
	logic signed [31:0] lo_s2;
	logic signed [31:0] hi_s2;

	logic signed [33:0] lo34_w;
	logic signed [33:0] hi34_w;
	logic signed [33:0] q34_w;
	logic               rnd_w;
	logic signed [33:0] res_w;

	logic               done_q;
	logic signed [31:0] value_q;

	// range width: span for integer draws, magnitude for real draws
	assign diff_w = $signed({high[31], high}) - $signed({low[31], low});
	assign span_w = $unsigned(diff_w) + 33'd1;
	assign mag_w  = diff_w[32] ? $unsigned(-diff_w) : $unsigned(diff_w);

	// stage 1: operand select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		real_s1 <= req.is_real;
		neg_s1  <= diff_w[32];
		f_s1    <= fraction_in;
		opnd_s1 <= req.is_real ? mag_w : span_w;
		lo_s1   <= low;
		hi_s1   <= high;
	end

	// stage 2: 32x33 product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		real_s2 <= real_s1;
		neg_s2  <= neg_s1;
		prod_s2 <= 65'(f_s1) * 65'(opnd_s1);
		lo_s2   <= lo_s1;
		hi_s2   <= hi_s1;
	end

	// stage 3: offset from low, ceiling when the range runs downward, integer draws clamped to high
	assign lo34_w = {{2{lo_s2[31]}}, lo_s2};
	assign hi34_w = {{2{hi_s2[31]}}, hi_s2};
	assign q34_w  = {1'b0, prod_s2[64:32]};
	assign rnd_w  = real_s2 && neg_s2 && (prod_s2[31:0] != 32'd0);

	always_comb begin
		if (real_s2 && neg_s2) begin
			res_w = lo34_w - q34_w - 34'(rnd_w);
		end else begin
			res_w = lo34_w + q34_w;
		end
		if (!real_s2 && (res_w > hi34_w)) begin
			res_w = hi34_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= res_w[31:0];
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

// File: test/subtractive_lagged_fibonacci_rng_top_test.sv
`timescale 1ns / 1ps

module subtractive_lagged_fibonacci_rng_top_test import slfr_pkg::*; ();

	// op code left unused by the block
	localparam op_t OP_UNUSED = 2'd3;
	// seed register after reset
	localparam logic [31:0] SEED_RESET = 32'h8000_0000;
	// 1e-9 in Q0.32, rounded
	localparam logic [31:0] WARM_START = 32'd4;
	localparam logic [31:0] MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

	typedef struct {
		logic [31:0] fraction;
		logic [31:0] value;
	} draw_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // low [31:0], high [63:32]
	logic [1:0]  s_tuser = '0;   // op [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // fraction [31:0], value [63:32]
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// generator state as the block should hold it
	logic [31:0]  lag_tab [TABLE_LEN] = '{default: '0};
	int unsigned  rd_idx = 0;
	logic [31:0]  seed_reg = SEED_RESET;

	draw_result_t expected_draws [$];
	int           failures = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;

	subtractive_lagged_fibonacci_rng_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// one pass of both lags over the table, modulo 2^32
	function automatic void refresh_table();
		for (int k = 0; k < SHORT_LAG; k++)
			lag_tab[k] = lag_tab[k] - lag_tab[k + LONG_LAG];
		for (int k = SHORT_LAG; k < TABLE_LEN; k++)
			lag_tab[k] = lag_tab[k] - lag_tab[k - SHORT_LAG];
	endfunction

	// permuted fill from the seed, then three refreshes
	function automatic void warm_up_table();
		logic [31:0] nxt;
		logic [31:0] prev;
		int          pos;
		nxt = WARM_START;
		prev = seed_reg;
		foreach (lag_tab[k])
			lag_tab[k] = '0;
		lag_tab[TABLE_LEN - 1] = seed_reg;
		for (int j = 1; j <= FILL_MOD; j++) begin
			pos = (FILL_STEP * j) % FILL_MOD;
			lag_tab[pos] = nxt;
			nxt = prev - nxt;
			prev = lag_tab[pos];
		end
		refresh_table();
		refresh_table();
		refresh_table();
		rd_idx = 0;
	endfunction

	// advance the read pointer, refreshing when it wraps
	function automatic logic [31:0] next_fraction();
		int unsigned i;
		i = (rd_idx > TABLE_LEN - 1) ? TABLE_LEN - 1 : rd_idx;
		i++;
		if (i >= TABLE_LEN) begin
			i = 1;
			refresh_table();
		end
		rd_idx = i;
		return lag_tab[i];
	endfunction

	// expected output word for one accepted request
	function automatic draw_result_t predict_draw(op_t op, logic [31:0] lo_bits,
			logic [31:0] hi_bits);
		draw_result_t r;
		longint       lo;
		longint       hi;
		longint       res;
		longint       diff;
		logic [63:0]  span;
		logic [63:0]  mag;
		logic [63:0]  prod;
		logic [63:0]  q;
		logic [31:0]  f;
		lo = $signed(lo_bits);
		hi = $signed(hi_bits);
		f = '0;
		res = 0;
		case (op)
			OP_WARM: begin
				warm_up_table();
			end
			OP_INT: begin
				// empty range answers low without a draw
				if (lo >= hi) begin
					res = lo;
				end else begin
					span = 64'(hi - lo) + 64'd1;
					f = next_fraction();
					prod = {32'd0, f} * span;
					res = lo + longint'(prod >> 32);
					if (res > hi)
						res = hi;
				end
			end
			OP_REAL: begin
				diff = hi - lo;
				mag = (diff < 0) ? 64'(-diff) : 64'(diff);
				f = next_fraction();
				prod = mag * {32'd0, f};
				q = prod >> 32;
				// floor toward minus infinity for a falling range
				if (diff < 0) begin
					if (prod[31:0] != 0)
						q++;
					res = lo - longint'(q);
				end else begin
					res = lo + longint'(q);
				end
			end
			default: begin
			end
		endcase
		r.fraction = f;
		r.value = res[31:0];
		return r;
	endfunction

	// result checker and random output stall
	always @(posedge clk) begin
		draw_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_draws.size() == 0) begin
				$error("unexpected word: fraction %h value %h", m_tdata[31:0], m_tdata[63:32]);
				failures++;
			end else begin
				e = expected_draws.pop_front();
				if (m_tdata[31:0] !== e.fraction) begin
					$error("fraction: expected %h, got %h", e.fraction, m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[63:32] !== e.value) begin
					$error("value: expected %h, got %h", e.value, m_tdata[63:32]);
					failures++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// offer one request word and wait for it to be taken
	task automatic send_word(op_t op, logic [31:0] lo, logic [31:0] hi);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {hi, lo};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_draws.push_back(predict_draw(op, lo, hi));
	endtask

	// stop offering and wait for every expected word
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_draws.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		seed_reg = v;
	endtask

	// request with random op and bounds shaped per op
	task automatic send_random();
		int unsigned pick;
		logic [31:0] lo;
		logic [31:0] hi;
		op_t         op;
		pick = $urandom_range(99);
		lo = $urandom;
		hi = $urandom;
		if (pick < 2) begin
			op = OP_WARM;
		end else if (pick < 3) begin
			op = OP_UNUSED;
		end else if (pick < 65) begin
			op = OP_INT;
			case ($urandom_range(4))
				0: hi = lo + $urandom_range(1, 100);
				1: begin
					lo = MOST_NEG + $urandom_range(0, 3);
					hi = MOST_POS - $urandom_range(0, 3);
				end
				2: hi = lo - $urandom_range(0, 5);
				default: begin
				end
			endcase
		end else begin
			op = OP_REAL;
			case ($urandom_range(3))
				0: begin
					lo = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
					hi = lo + $urandom_range(0, 32'h0008_0000) - 32'h0002_0000;
				end
				1: hi = lo;
				default: begin
				end
			endcase
		end
		send_word(op, lo, hi);
	endtask

	// zero table after reset yields zero fractions
	task automatic test_draw_before_warm_up();
		send_word(OP_INT, MOST_NEG, MOST_POS);
		send_word(OP_REAL, 32'h0001_0000, 32'hFFFF_0000);
		send_word(OP_INT, 32'd5, 32'd9);
	endtask

	// every op and the extremes of the bounds
	task automatic test_ops_and_bounds();
		send_word(OP_WARM, $urandom, $urandom);
		send_word(OP_INT, MOST_NEG, MOST_POS);
		send_word(OP_INT, MOST_POS, MOST_POS);
		send_word(OP_INT, MOST_POS, MOST_NEG);
		send_word(OP_INT, 32'd0, 32'd1);
		send_word(OP_INT, MOST_POS - 32'd1, MOST_POS);
		send_word(OP_REAL, MOST_NEG, MOST_POS);
		send_word(OP_REAL, MOST_POS, MOST_NEG);
		send_word(OP_REAL, 32'h0003_8000, 32'h0003_8000);
		send_word(OP_REAL, 32'hFFFF_0000, 32'h0000_0000);
		send_word(OP_UNUSED, MOST_NEG, MOST_POS);
		send_word(OP_UNUSED, MOST_POS, 32'hFFFF_FFFF);
	endtask

	// warm-up from the extreme seeds
	task automatic test_seed_extremes();
		write_seed(32'h0000_0000);
		send_word(OP_WARM, 32'd0, 32'd0);
		send_word(OP_INT, 32'hFFFF_FF00, 32'h0000_00FF);
		send_word(OP_REAL, MOST_NEG, MOST_POS);
		write_seed(32'hFFFF_FFFF);
		send_word(OP_WARM, 32'd0, 32'd0);
		send_word(OP_INT, MOST_NEG, MOST_POS);
		send_word(OP_REAL, MOST_POS, MOST_NEG);
	endtask

	// reseed, warm up, then a long random run under one idling pattern
	task automatic test_random_phase(int idle, int stall, int count);
		write_seed($urandom);
		idle_pct = idle;
		stall_pct = stall;
		send_word(OP_WARM, $urandom, $urandom);
		repeat (count)
			send_random();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_draw_before_warm_up();
		test_ops_and_bounds();
		test_seed_extremes();
		test_random_phase(0, 0, 290);
		test_random_phase(54, 0, 290);
		test_random_phase(0, 54, 290);
		test_random_phase(32, 32, 290);
		wait_drained();
		repeat (300) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// overall run limit
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
